// File: hw/rtl/toroidal_life_generation_step_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the toroidal life grid
// Shorthand for clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_LIFE_GENERATION_STEP_MACROS_SVH
`define TOROIDAL_LIFE_GENERATION_STEP_MACROS_SVH

// Same-cycle implication on the rising edge of clk.
`define TLGS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on the rising edge of clk.
`define TLGS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/tlgs_pkg.sv
// ----------------------------------------------------------------------------
// Toroidal life grid package
// Shared constants, codes, types and the B3/S23 row evaluation function.
// ----------------------------------------------------------------------------
package tlgs_pkg;

	localparam int ROW_W        = 64;
	localparam int CNT_W        = 7;
	localparam int MODE_W       = 2;
	localparam int IDX_W        = 6;
	localparam int CFG_IDX_W    = 1;
	localparam int DEF_MAX_ROWS = 64;

	localparam logic [CNT_W-1:0] MAX_COLS  = 7'd64;
	localparam logic [CNT_W-1:0] REG_RESET = 7'd64;

	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT  = 4'd2;

	typedef struct packed {
		logic [ROW_W-1:0] next_row;
		logic             changed;
	} eval_stat_t;

	// Bit j is set for every column j below cols.
	function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] cols);
		logic [ROW_W-1:0] m;
		for (int j = 0; j < ROW_W; j++) begin
			m[j] = (7'(j) < cols);
		end
		return m;
	endfunction

	// Next generation of the center row; neighbors wrap at cols, so on a
	// one-column grid the cell itself is seen as its left and right neighbor.
	function automatic logic [ROW_W-1:0] life_next(
		input logic [ROW_W-1:0] up,
		input logic [ROW_W-1:0] cen,
		input logic [ROW_W-1:0] dn,
		input logic [CNT_W-1:0] cols
	);
		logic [ROW_W-1:0] nx;
		logic [5:0]       lf;
		logic [5:0]       rt;
		logic [3:0]       n;
		for (int j = 0; j < ROW_W; j++) begin
			lf = (j == 0) ? 6'(cols - 7'd1) : 6'(j - 1);
			rt = (7'(j) == cols - 7'd1) ? 6'd0 : 6'(j + 1);
			n = 4'(up[lf]) + 4'(up[j]) + 4'(up[rt]) + 4'(cen[lf]) + 4'(cen[rt])
				+ 4'(dn[lf]) + 4'(dn[j]) + 4'(dn[rt]);
			nx[j] = (7'(j) < cols) && ((n == BIRTH_COUNT) || (cen[j] && (n == KEEP_COUNT)));
		end
		return nx;
	endfunction

endpackage

// File: hw/rtl/tlgs_ifs.sv
// ----------------------------------------------------------------------------
// Toroidal life grid channels
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface tlgs_in_if;
	logic                         valid;
	logic                         ready;
	logic [tlgs_pkg::MODE_W-1:0] mode;
	logic [tlgs_pkg::IDX_W-1:0]  row_index;
	logic [tlgs_pkg::ROW_W-1:0]  row_cells;

	modport source(output valid, mode, row_index, row_cells, input ready);
	modport sink(input valid, mode, row_index, row_cells, output ready);
endinterface

interface tlgs_out_if;
	logic                        valid;
	logic                        ready;
	logic [tlgs_pkg::ROW_W-1:0] row_value;
	logic                        changed;

	modport source(output valid, row_value, changed, input ready);
	modport sink(input valid, row_value, changed, output ready);
endinterface

interface tlgs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tlgs_pkg::CFG_IDX_W-1:0] index;
	logic [tlgs_pkg::CNT_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/toroidal_life_generation_step.sv
// ----------------------------------------------------------------------------
// Toroidal life generation step
// Row-addressed Game of Life grid (B3/S23) on a torus, with a step command.
// ----------------------------------------------------------------------------
// A write or an unused-mode item loads its result word when accepted, a read from
// the registered memory word once the result register is free, and a step after
// clearing the rows past the count in the new bank. Reads take no new item until
// their word is loaded, writes one per cycle while the result side keeps up, and
// a step holds the input for its whole walk over the single memory read port.
// Reset: asynchronous; no item is taken until bank 0 is cleared, one row per cycle.
// ----------------------------------------------------------------------------
`include "toroidal_life_generation_step_macros.svh"

module toroidal_life_generation_step #(
	parameter int MAX_ROWS = tlgs_pkg::DEF_MAX_ROWS
) (
	input  logic          clk,
	input  logic          arst_n,
	tlgs_cfg_if.sink      cfg,
	tlgs_in_if.sink       items,
	tlgs_out_if.source    results
);
	import tlgs_pkg::*;

	// Row address width and the width of a counter that reaches MAX_ROWS.
	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int FW = $clog2(MAX_ROWS + 1);

	localparam logic [2:0] ST_FILL = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_STEP = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// Control state.
	logic [2:0]       state_q;
	logic             bank_q;
	logic [CNT_W-1:0] row_count_q;
	logic [CNT_W-1:0] col_count_q;
	logic             out_valid_q;
	logic [FW-1:0]    fill_cnt_q;
	logic             fill_step_q;
	logic [7:0]       rd_cnt_q;
	logic [7:0]       sh_cnt_q;
	logic             rv_s1;
	logic             win_v_s2;
	logic             any_q;

	// Payload registers.
	logic [ROW_W-1:0] out_value_q;
	logic             out_changed_q;
	logic             rd_hit_q;
	logic [AW-1:0]    wrow_s2;

	// Derived signals.
	logic [CNT_W-1:0] rows_eff;
	logic [CNT_W-1:0] cols_eff;
	logic [ROW_W-1:0] mask;
	logic             in_fire;
	logic             out_free;
	logic             out_set;
	logic             item_hit;
	logic [7:0]       last_rd;
	logic             issue;
	logic [7:0]       rd_row_step;
	logic             wr_en;
	logic             wr_bank;
	logic [AW-1:0]    wr_row;
	logic [ROW_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_row;
	logic [ROW_W-1:0] rd_data;
	eval_stat_t       stat;

	// Register values outside their range saturate to the usable grid size.
	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = 7'd1;
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows_eff = 7'(MAX_ROWS);
		end else begin
			rows_eff = row_count_q;
		end
		if (col_count_q == '0) begin
			cols_eff = 7'd1;
		end else if (col_count_q > MAX_COLS) begin
			cols_eff = MAX_COLS;
		end else begin
			cols_eff = col_count_q;
		end
	end

	assign mask     = col_mask(cols_eff);
	assign out_free = !out_valid_q || results.ready;
	assign in_fire  = items.valid && items.ready;
	assign item_hit = ({1'b0, items.row_index} < rows_eff);

	// A result word is loaded by a write or unused-mode item when it is taken,
	// at the end of a read, and at the end of a step.
	assign out_set = (in_fire && (items.mode != MODE_READ) && (items.mode != MODE_STEP))
		|| ((state_q == ST_READ) && out_free) || ((state_q == ST_FIN) && out_free);

	assign items.ready       = (state_q == ST_IDLE) && out_free;
	assign cfg.ready         = 1'b1;
	assign results.valid     = out_valid_q;
	assign results.row_value = out_value_q;
	assign results.changed   = out_changed_q;

	// A step reads the source rows in the order last, 0, 1, ..., last, 0, so
	// that after each read the window holds the rows above, at and below the
	// next row to compute. That is rows + 2 reads in all.
	assign last_rd = {1'b0, rows_eff} + 8'd1;
	assign issue   = (state_q == ST_STEP) && (rd_cnt_q <= last_rd);

	always_comb begin
		if (rd_cnt_q == 8'd0) begin
			rd_row_step = {1'b0, rows_eff} - 8'd1;
		end else if (rd_cnt_q == last_rd) begin
			rd_row_step = 8'd0;
		end else begin
			rd_row_step = rd_cnt_q - 8'd1;
		end
	end

	// Write port: the clearing pass, the computed rows of a step, or a row
	// write item. These never overlap since each belongs to its own state.
	always_comb begin
		wr_en   = 1'b0;
		wr_bank = bank_q;
		wr_row  = '0;
		wr_data = '0;
		case (state_q)
			ST_FILL: begin
				wr_en   = (fill_cnt_q < FW'(MAX_ROWS));
				wr_bank = fill_step_q ? ~bank_q : 1'b0;
				wr_row  = AW'(fill_cnt_q);
			end
			ST_STEP: begin
				wr_en   = win_v_s2;
				wr_bank = ~bank_q;
				wr_row  = wrow_s2;
				wr_data = stat.next_row;
			end
			ST_IDLE: begin
				wr_en   = in_fire && (items.mode == MODE_WRITE) && item_hit;
				wr_row  = AW'(items.row_index);
				wr_data = items.row_cells & mask;
			end
			default: begin
			end
		endcase
	end

	// Read port: step reads always come from the active bank, while the
	// step writes only the other one, so no forwarding is needed.
	assign rd_en  = issue || (in_fire && (items.mode == MODE_READ));
	assign rd_row = issue ? AW'(rd_row_step) : AW'(items.row_index);

	tlgs_grid_mem #(
		.AW(AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr({wr_bank, wr_row}),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr({bank_q, rd_row}),
		.rd_data(rd_data)
	);

	tlgs_row_eval u_eval (
		.clk     (clk),
		.shift   (rv_s1),
		.in_row  (rd_data & mask),
		.cols_eff(cols_eff),
		.stat    (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			bank_q      <= 1'b0;
			row_count_q <= REG_RESET;
			col_count_q <= REG_RESET;
			out_valid_q <= 1'b0;
			fill_cnt_q  <= '0;
			fill_step_q <= 1'b0;
			rd_cnt_q    <= '0;
			sh_cnt_q    <= '0;
			rv_s1       <= 1'b0;
			win_v_s2    <= 1'b0;
			any_q       <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_ROW_COUNT: row_count_q <= cfg.data;
					CFG_COL_COUNT: col_count_q <= cfg.data;
					default: begin
					end
				endcase
			end
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end

			// The window is complete from the third read word on.
			rv_s1    <= issue;
			win_v_s2 <= rv_s1 && (sh_cnt_q >= 8'd2);
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + 8'd1;
			end
			if (rv_s1) begin
				sh_cnt_q <= sh_cnt_q + 8'd1;
			end

			case (state_q)
				ST_FILL: begin
					if (wr_en) begin
						fill_cnt_q <= fill_cnt_q + 1'b1;
					end else if (fill_step_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						case (items.mode)
							MODE_READ: state_q <= ST_READ;
							MODE_STEP: begin
								state_q  <= ST_STEP;
								rd_cnt_q <= '0;
								sh_cnt_q <= '0;
								any_q    <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_STEP: begin
					if (win_v_s2) begin
						any_q <= any_q | stat.changed;
						// After the last row in use, rows past the count are
						// cleared in the new bank.
						if (wrow_s2 == AW'(rows_eff - 7'd1)) begin
							state_q     <= ST_FILL;
							fill_step_q <= 1'b1;
							fill_cnt_q  <= FW'(rows_eff);
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						bank_q      <= ~bank_q;
						fill_step_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wrow_s2 <= AW'(sh_cnt_q - 8'd2);
		if (in_fire) begin
			rd_hit_q <= item_hit;
			if ((items.mode != MODE_READ) && (items.mode != MODE_STEP)) begin
				out_value_q   <= '0;
				out_changed_q <= 1'b0;
			end
		end
		if ((state_q == ST_READ) && out_free) begin
			out_value_q   <= rd_hit_q ? (rd_data & mask) : '0;
			out_changed_q <= 1'b0;
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_value_q   <= '0;
			out_changed_q <= any_q;
		end
	end

	`TLGS_ASSERT_IMP(a_ready_only_idle, items.ready, state_q == ST_IDLE, "item taken while busy")
	`TLGS_ASSERT_IMP(a_step_writes_other_bank, (state_q == ST_STEP) && wr_en, wr_bank != bank_q, "step wrote the active bank")
	`TLGS_ASSERT_NXT(a_bank_flips_at_end, state_q != ST_FIN, $stable(bank_q), "bank changed outside step end")
	`TLGS_ASSERT_IMP(a_window_in_step, rv_s1 || win_v_s2, state_q == ST_STEP, "window active outside a step")

endmodule

// File: hw/rtl/tlgs_grid_mem.sv
// ----------------------------------------------------------------------------
// Grid row memory
// Two banks of row words, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module tlgs_grid_mem #(
	parameter int AW = 6
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW:0]                wr_addr,
	input  logic [tlgs_pkg::ROW_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW:0]                rd_addr,
	output logic [tlgs_pkg::ROW_W-1:0] rd_data
);
	import tlgs_pkg::*;

	localparam int DEPTH = 2 ** (AW + 1);

	logic [ROW_W-1:0] mem_q [DEPTH];
	logic [ROW_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/tlgs_row_eval.sv
// ----------------------------------------------------------------------------
// Row window and evaluator
// Holds the rows above, at and below the current row and computes its next
// generation together with a flag for any changed cell.
// ----------------------------------------------------------------------------
module tlgs_row_eval (
	input  logic                       clk,
	input  logic                       shift,
	input  logic [tlgs_pkg::ROW_W-1:0] in_row,
	input  logic [tlgs_pkg::CNT_W-1:0] cols_eff,
	output tlgs_pkg::eval_stat_t       stat
);
	import tlgs_pkg::*;

	logic [ROW_W-1:0] up_q;
	logic [ROW_W-1:0] cen_q;
	logic [ROW_W-1:0] dn_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			up_q  <= cen_q;
			cen_q <= dn_q;
			dn_q  <= in_row;
		end
	end

	always_comb begin
		stat.next_row = life_next(up_q, cen_q, dn_q, cols_eff);
		stat.changed  = (stat.next_row != cen_q);
	end

endmodule

// File: bench/toroidal_life_generation_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal life grid testbench
// Loads rows, advances generations and reads rows back under many grid sizes,
// and checks every result word against a cycle-free model of the B3/S23 torus.
// ----------------------------------------------------------------------------
module toroidal_life_generation_step_tb;

	// The block has no name for the unused mode, so the bench gives it one.
	localparam logic [tlgs_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

	localparam int GRID_ROWS  = tlgs_pkg::DEF_MAX_ROWS;
	localparam int PHASES     = 10;
	localparam int PHASE_WORK = 190;

	// One expected result word.
	typedef struct {
		logic [tlgs_pkg::ROW_W-1:0] row_value;
		logic                       changed;
	} grid_word_t;

	// Shadow copy of the grid. It tracks both banks and the size registers,
	// and turns each accepted item into the result word it must produce.
	class life_grid_tracker;
		logic [tlgs_pkg::ROW_W-1:0] cells [2][GRID_ROWS];
		bit                         view_bank;
		logic [tlgs_pkg::CNT_W-1:0] rows_reg;
		logic [tlgs_pkg::CNT_W-1:0] cols_reg;
		grid_word_t                 pending_words[$];
		int unsigned                mismatches;
		int unsigned                words_checked;
		int unsigned                steps_run;
		int unsigned                steps_changed;
		int unsigned                reads_done;

		function new();
			foreach (cells[b, r]) cells[b][r] = '0;
			view_bank     = 1'b0;
			rows_reg      = tlgs_pkg::REG_RESET;
			cols_reg      = tlgs_pkg::REG_RESET;
			mismatches    = 0;
			words_checked = 0;
			steps_run     = 0;
			steps_changed = 0;
			reads_done    = 0;
		endfunction

		function void set_reg(input logic [tlgs_pkg::CFG_IDX_W-1:0] idx,
				input logic [tlgs_pkg::CNT_W-1:0] data);
			if (idx == tlgs_pkg::CFG_ROW_COUNT) rows_reg = data;
			else cols_reg = data;
		endfunction

		// Register values outside the legal range saturate to it.
		function int live_rows();
			int r;
			r = int'(rows_reg);
			if (r < 1) r = 1;
			if (r > GRID_ROWS) r = GRID_ROWS;
			return r;
		endfunction

		function int live_cols();
			int c;
			c = int'(cols_reg);
			if (c < 1) c = 1;
			if (c > 64) c = 64;
			return c;
		endfunction

		function logic [tlgs_pkg::ROW_W-1:0] used_cols();
			int c;
			c = live_cols();
			if (c >= 64) return '1;
			return (64'd1 << c) - 64'd1;
		endfunction

		// One generation: writes the other bank and flips to it. Rows past
		// the row count come out dead and never count as a change.
		function logic advance();
			int                         rows;
			int                         cols;
			int                         up;
			int                         dn;
			int                         lf;
			int                         rt;
			int                         n;
			logic [tlgs_pkg::ROW_W-1:0] m;
			logic [tlgs_pkg::ROW_W-1:0] wu;
			logic [tlgs_pkg::ROW_W-1:0] wc;
			logic [tlgs_pkg::ROW_W-1:0] wd;
			logic [tlgs_pkg::ROW_W-1:0] nxt;
			bit                         src;
			logic                       any;
			rows = live_rows();
			cols = live_cols();
			m    = used_cols();
			src  = view_bank;
			any  = 1'b0;
			for (int i = 0; i < GRID_ROWS; i++) begin
				nxt = '0;
				if (i < rows) begin
					up = (i + rows - 1) % rows;
					dn = (i + 1) % rows;
					wu = cells[src][up] & m;
					wc = cells[src][i] & m;
					wd = cells[src][dn] & m;
					for (int j = 0; j < cols; j++) begin
						lf = (j + cols - 1) % cols;
						rt = (j + 1) % cols;
						n = int'(wu[lf]) + int'(wu[j]) + int'(wu[rt])
							+ int'(wc[lf]) + int'(wc[rt])
							+ int'(wd[lf]) + int'(wd[j]) + int'(wd[rt]);
						if (n == int'(tlgs_pkg::BIRTH_COUNT)
								|| (wc[j] && n == int'(tlgs_pkg::KEEP_COUNT)))
							nxt[j] = 1'b1;
					end
					if (nxt != wc) any = 1'b1;
				end
				cells[!src][i] = nxt;
			end
			view_bank = !src;
			return any;
		endfunction

		function void accept_item(input logic [tlgs_pkg::MODE_W-1:0] mode,
				input logic [tlgs_pkg::IDX_W-1:0] idx,
				input logic [tlgs_pkg::ROW_W-1:0] row_in);
			grid_word_t w;
			w.row_value = '0;
			w.changed   = 1'b0;
			case (mode)
				tlgs_pkg::MODE_WRITE: begin
					if (int'(idx) < live_rows()) cells[view_bank][idx] = row_in & used_cols();
				end
				tlgs_pkg::MODE_STEP: begin
					w.changed = advance();
					steps_run++;
					if (w.changed) steps_changed++;
				end
				tlgs_pkg::MODE_READ: begin
					reads_done++;
					if (int'(idx) < live_rows()) w.row_value = cells[view_bank][idx] & used_cols();
				end
				default: begin
				end
			endcase
			pending_words.insert(pending_words.size(), w);
		endfunction

		function void check_word(input logic [tlgs_pkg::ROW_W-1:0] row_value,
				input logic changed);
			grid_word_t w;
			if (pending_words.size() == 0) begin
				$error("result word with none expected: row_value %h changed %b",
					row_value, changed);
				mismatches++;
				return;
			end
			w = pending_words.pop_front();
			words_checked++;
			if (row_value !== w.row_value) begin
				$error("row_value: expected %h, actual %h", w.row_value, row_value);
				mismatches++;
			end
			if (changed !== w.changed) begin
				$error("changed: expected %b, actual %b", w.changed, changed);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	bit               idle_on;
	int unsigned      useful_items;
	int unsigned      grid_sizes;
	int               stall_left;
	life_grid_tracker track;

	tlgs_cfg_if cfg_ch();
	tlgs_in_if  item_ch();
	tlgs_out_if result_ch();

	toroidal_life_generation_step dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.items   (item_ch),
		.results (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Row patterns of graded density, so that some grids die out quickly,
	// some stay busy and some are crowded enough to collapse.
	function automatic logic [tlgs_pkg::ROW_W-1:0] random_row(input int density);
		logic [tlgs_pkg::ROW_W-1:0] a;
		logic [tlgs_pkg::ROW_W-1:0] b;
		logic [tlgs_pkg::ROW_W-1:0] c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case (density)
			0: return a & b & c;
			1: return a & b;
			2: return a;
			default: return a | b;
		endcase
	endfunction

	// Offers one item word. Inputs move only on the falling edge, and the
	// handshake is judged on the rising edge. Valid stays high from one word
	// to the next unless an idle burst drops it first.
	task automatic send_item(input logic [tlgs_pkg::MODE_W-1:0] mode,
			input logic [tlgs_pkg::IDX_W-1:0] idx,
			input logic [tlgs_pkg::ROW_W-1:0] row_in);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_ch.valid     = 1'b1;
		item_ch.mode      = mode;
		item_ch.row_index = idx;
		item_ch.row_cells = row_in;
		do @(posedge clk); while (!item_ch.ready);
		// Writes and reads past the row count and the unused mode do nothing,
		// so they do not count as work done on the grid.
		if (mode == tlgs_pkg::MODE_STEP
				|| (mode != MODE_NONE && int'(idx) < track.live_rows()))
			useful_items++;
		track.accept_item(mode, idx, row_in);
	endtask

	// Stops offering items and waits until every expected word has arrived.
	// Every item gives exactly one word, so an empty queue means the block is idle.
	task automatic drain();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (track.pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tlgs_pkg::CFG_IDX_W-1:0] idx,
			input logic [tlgs_pkg::CNT_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		do @(posedge clk); while (!cfg_ch.ready);
		track.set_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// A well-formed run: fill every row in use, then advance a few
	// generations and read rows back between the steps. The step words carry
	// random index and row bits, which the block must ignore.
	task automatic life_episode();
		int rows;
		int density;
		rows    = track.live_rows();
		density = $urandom_range(0, 3);
		for (int r = 0; r < rows; r++)
			send_item(tlgs_pkg::MODE_WRITE, 6'(r), random_row(density));
		repeat ($urandom_range(1, 6)) begin
			send_item(tlgs_pkg::MODE_STEP, 6'($urandom_range(0, 63)), {$urandom, $urandom});
			repeat ($urandom_range(1, 3))
				send_item(tlgs_pkg::MODE_READ, 6'($urandom_range(0, rows - 1)),
					{$urandom, $urandom});
		end
	endtask

	// Anything the fields allow: any mode including the unused one, and any
	// row index, so writes and reads past the row count show up as well.
	task automatic noise_burst();
		repeat ($urandom_range(1, 8))
			send_item(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
				random_row($urandom_range(0, 3)));
	endtask

	// Result side: ready drops in random bursts while idling is enabled.
	initial begin
		result_ch.ready = 1'b0;
		stall_left      = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ch.ready = 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				result_ch.ready = 1'b0;
				stall_left      = $urandom_range(1, 4) - 1;
			end else begin
				result_ch.ready = 1'b1;
			end
		end
	end

	// Every accepted result word is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			track.check_word(result_ch.row_value, result_ch.changed);
	end

	initial begin
		int rows_cfg[PHASES];
		int cols_cfg[PHASES];
		track             = new();
		idle_on           = 1'b1;
		useful_items      = 0;
		grid_sizes        = 1;
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.mode      = tlgs_pkg::MODE_WRITE;
		item_ch.row_index = '0;
		item_ch.row_cells = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = tlgs_pkg::CFG_ROW_COUNT;
		cfg_ch.data       = '0;

		// Grid sizes for the random phases. Register values of zero and above
		// the maximum must saturate; the one-row and one-column grids make
		// the wrapped neighbors land on the cell's own row or column. The
		// last phase runs the full grid with no idling on either side.
		rows_cfg = '{64, 127, 1, 64, 2, 3, 0, 0, 0, 64};
		cols_cfg = '{64, 127, 64, 1, 2, 3, 0, 0, 0, 64};
		rows_cfg[7] = $urandom_range(1, 64);
		cols_cfg[7] = $urandom_range(1, 64);
		rows_cfg[8] = $urandom_range(0, 127);
		cols_cfg[8] = $urandom_range(0, 127);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part on the reset size of 64 by 64. A full row at the top edge
		// and set bits at the bottom edge exercise the vertical wrap, the corner bits the
		// horizontal one, and two steps bring the bank back to where it began.
		send_item(tlgs_pkg::MODE_WRITE, 6'd0, '1);
		send_item(tlgs_pkg::MODE_WRITE, 6'd63, 64'h8000_0000_0000_0001);
		send_item(tlgs_pkg::MODE_WRITE, 6'd1, 64'h5555_5555_5555_5555);
		send_item(tlgs_pkg::MODE_READ, 6'd0, '0);
		send_item(tlgs_pkg::MODE_READ, 6'd63, '1);
		send_item(MODE_NONE, 6'd63, '1);
		send_item(tlgs_pkg::MODE_STEP, 6'd0, '0);
		send_item(tlgs_pkg::MODE_READ, 6'd0, '0);
		send_item(tlgs_pkg::MODE_READ, 6'd63, '0);
		send_item(tlgs_pkg::MODE_STEP, 6'd63, '1);
		send_item(tlgs_pkg::MODE_READ, 6'd1, '0);
		drain();

		// A 2 by 3 grid: bits past the column count are cleared on a write,
		// and a write or read past the row count does nothing.
		write_reg(tlgs_pkg::CFG_ROW_COUNT, 7'd2);
		write_reg(tlgs_pkg::CFG_COL_COUNT, 7'd3);
		send_item(tlgs_pkg::MODE_WRITE, 6'd0, '1);
		send_item(tlgs_pkg::MODE_WRITE, 6'd40, '1);
		send_item(tlgs_pkg::MODE_READ, 6'd0, '0);
		send_item(tlgs_pkg::MODE_READ, 6'd40, '0);
		send_item(tlgs_pkg::MODE_STEP, 6'd0, '0);
		send_item(tlgs_pkg::MODE_READ, 6'd1, '0);
		drain();

		// Zero in both registers means a single cell, which sees itself as all
		// eight neighbors and so dies on the first step and stays dead.
		write_reg(tlgs_pkg::CFG_ROW_COUNT, 7'd0);
		write_reg(tlgs_pkg::CFG_COL_COUNT, 7'd0);
		send_item(tlgs_pkg::MODE_WRITE, 6'd0, '1);
		send_item(tlgs_pkg::MODE_STEP, 6'd0, '0);
		send_item(tlgs_pkg::MODE_READ, 6'd0, '0);
		send_item(tlgs_pkg::MODE_STEP, 6'd0, '0);
		grid_sizes += 2;

		// Random part: mostly whole fill-step-read runs, with noise mixed in.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == PHASES - 1) idle_on = 1'b0;
			write_reg(tlgs_pkg::CFG_ROW_COUNT, 7'(rows_cfg[p]));
			write_reg(tlgs_pkg::CFG_COL_COUNT, 7'(cols_cfg[p]));
			grid_sizes++;
			begin
				int unsigned target;
				target = useful_items + PHASE_WORK;
				while (useful_items < target) begin
					if ($urandom_range(0, 9) < 7) life_episode();
					else noise_burst();
				end
			end
		end
		drain();

		// A step walks every row, so allow about that long for any stray word.
		repeat (GRID_ROWS + 16) @(posedge clk);

		$display("Checked %0d result words over %0d grid sizes.", track.words_checked,
			grid_sizes);
		$display("That took %0d generation steps (%0d with a change) and %0d row reads.",
			track.steps_run, track.steps_changed, track.reads_done);
		if (track.mismatches == 0 && track.pending_words.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Hang guard, well beyond the slowest legal run of back-to-back steps
	// with every gap and stall at its longest.
	initial begin
		#10ms;
		$display("Timed out with %0d result words still expected.",
			track.pending_words.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
